### rtl/core/form_field_extract_decode_assert.svh
// Assertion macros shared by the form field extractor RTL.
`ifndef FORM_FIELD_EXTRACT_DECODE_ASSERT_SVH
`define FORM_FIELD_EXTRACT_DECODE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("form field extractor: implication check failed");

// Next-cycle implication, disabled during reset.
`define FFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("form field extractor: next-cycle check failed");

`endif

### rtl/core/ffe_pkg.sv
// Types, constants and helper functions of the form field extractor.
`default_nettype none

package ffe_pkg;

   localparam int KEY_MAX_BYTES = 8;
   localparam int KEY_POS_W     = $clog2(KEY_MAX_BYTES + 1);
   localparam int KEY_IDX_W     = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

   localparam int BYTE_W    = 8;
   localparam int KEY_W     = 64;
   localparam int KEY_LEN_W = 4;
   localparam int VLEN_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = KEY_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = 2;

   localparam logic [KEY_W-1:0]     KEY_BYTES_RST     = 64'd1684632435;
   localparam logic [KEY_LEN_W-1:0] KEY_CHARS_RST     = 4'd4;
   localparam logic [VLEN_W-1:0]    MAX_VALUE_LEN_RST = 8'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CHARS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE_LEN = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
   localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
   localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
   localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'd10;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND       = 2'd0,
      ST_NOT_FOUND   = 2'd1,
      ST_DECODE_FAIL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_KEY   = 2'd0,
      PH_SKIP  = 2'd1,
      PH_VALUE = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_PCT  = 2'd1,
      ESC_HIGH = 2'd2
   } esc_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key_bytes;
      logic [KEY_LEN_W-1:0] key_chars;
      logic [VLEN_W-1:0]    max_value_len;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value_byte;
      logic              is_status;
      status_type        status;
      logic              last_of_run;
   } result_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      result_type        first;
      result_type        second;
      logic              body_end;
   } step_type;

   // Bit 4 flags a character that is not a hex digit; bits 3:0 hold the nibble.
   function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
      logic [4:0] r;
      r = 5'b1_0000;
      if (c >= CH_0 && c <= CH_9) begin
         r = {1'b0, 4'(c - CH_0)};
      end else if (c >= CH_LA && c <= CH_LF) begin
         r = {1'b0, 4'(c - CH_LA + HEX_ALPHA_BASE)};
      end else if (c >= CH_UA && c <= CH_UF) begin
         r = {1'b0, 4'(c - CH_UA + HEX_ALPHA_BASE)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ffe_req_if.sv
// Body byte channel of the form field extractor.
`default_nettype none

interface ffe_req_if;
   logic                        valid;
   logic                        ready;
   logic [ffe_pkg::BYTE_W-1:0]  body_byte;
   logic                        body_last;

   modport source (output valid, output body_byte, output body_last, input ready);
   modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

`default_nettype wire

### rtl/core/ffe_rsp_if.sv
// Result channel of the form field extractor.
`default_nettype none

interface ffe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffe_pkg::BYTE_W-1:0]    value_byte;
   logic                          is_status;
   logic [ffe_pkg::STATUS_W-1:0]  status;
   logic                          last_of_run;

   modport source (output valid, output value_byte, output is_status, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input value_byte, input is_status, input status,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/form_field_extract_decode.sv
// Top level of the url-encoded form field extractor and decoder.
`default_nettype none

`include "form_field_extract_decode_assert.svh"

// Form field extractor: feed a url-encoded form body one byte per transaction
// on req_bus (body_last on the final byte; a zero byte also ends the body and
// is not itself body text). The block looks for the first pair whose name
// equals the csr key and streams that pair's value out decoded on rsp_bus,
// with '+' turned into a space and %XX into one byte. Every body closes with
// exactly one status transaction (is_status set): 0 found, 1 not found,
// 2 decode failure; last_of_run marks the final result of each input byte.
// Rate: one body byte per cycle while the queue has room for its results. A
// byte moves from the input register through one decode step into a two-slot
// result queue, so a new byte is taken while results still wait on rsp_bus.
// The queue drains one transaction a cycle while rsp_bus is ready; a byte that
// yields two results (a value byte together with body_last) holds in the input
// register until the queue is empty or empties in that cycle, so with rsp_bus
// ready it is held back only when the byte before it also left two results.
// Write the csr registers only while no body is in flight: index 0 key bytes
// (first character lowest), 1 key length (clamped to eight), 2 maximum value
// length.

module form_field_extract_decode (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ffe_req_if.sink                             req_bus,
   ffe_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [ffe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ffe_pkg::CSR_W-1:0]      csr_wdata
);

   // Configuration registers.
   ffe_pkg::cfg_type                 cfg_ff;

   // Input register: holds one body byte until the decode step takes it.
   logic                             in_valid_ff;
   logic [ffe_pkg::BYTE_W-1:0]       in_byte_ff;
   logic                             in_last_ff;

   ffe_pkg::step_type                step;
   ffe_pkg::phase_type               parse_phase;
   ffe_pkg::result_type              head;
   logic                             head_valid;
   logic [ffe_pkg::QCNT_W-1:0]       free_count;
   logic [ffe_pkg::QCNT_W-1:0]       push_count;
   logic                             advance;
   logic                             req_take;

   // Advance the held byte only when the queue has room for all its results.
   assign advance    = in_valid_ff && (step.count <= free_count);
   assign push_count = advance ? step.count : '0;

   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_bytes     <= ffe_pkg::KEY_BYTES_RST;
         cfg_ff.key_chars     <= ffe_pkg::KEY_CHARS_RST;
         cfg_ff.max_value_len <= ffe_pkg::MAX_VALUE_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            ffe_pkg::CSR_KEY_BYTES: begin
               cfg_ff.key_bytes <= csr_wdata;
            end
            ffe_pkg::CSR_KEY_CHARS: begin
               cfg_ff.key_chars <= csr_wdata[ffe_pkg::KEY_LEN_W-1:0];
            end
            ffe_pkg::CSR_MAX_VALUE_LEN: begin
               cfg_ff.max_value_len <= csr_wdata[ffe_pkg::VLEN_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Hold the valid flag; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.body_byte;
         in_last_ff <= req_bus.body_last;
      end
   end

   ffe_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .body_byte   (in_byte_ff),
      .body_last   (in_last_ff),
      .cfg         (cfg_ff),
      .step        (step),
      .parse_phase (parse_phase)
   );

   ffe_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (step.first),
      .push_second (step.second),
      .pop_ready   (rsp_bus.ready),
      .head        (head),
      .head_valid  (head_valid),
      .free_count  (free_count)
   );

   assign rsp_bus.valid       = head_valid;
   assign rsp_bus.value_byte  = head.value_byte;
   assign rsp_bus.is_status   = head.is_status;
   assign rsp_bus.status      = head.status;
   assign rsp_bus.last_of_run = head.last_of_run;

   // A decoded value byte is never zero: zero closes the value as a failure.
   `FFE_ASSERT_IMPLY(a_value_nonzero, clock, reset, rsp_bus.valid && !rsp_bus.is_status, rsp_bus.value_byte != 8'd0)
   // The closing status is always the final result of its input byte.
   `FFE_ASSERT_IMPLY(a_status_ends_run, clock, reset, rsp_bus.valid && rsp_bus.is_status, rsp_bus.last_of_run)
   // A body end consumed by the decode step rearms the key comparison.
   `FFE_ASSERT_NEXT(a_body_end_rearms, clock, reset, advance && step.body_end, parse_phase == ffe_pkg::PH_KEY)

endmodule

`default_nettype wire

### rtl/core/ffe_parse.sv
// Per-byte parse state and decode step of the form field extractor.
`default_nettype none

module ffe_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [ffe_pkg::BYTE_W-1:0]  body_byte,
   input  wire logic                        body_last,
   input  wire ffe_pkg::cfg_type            cfg,
   output ffe_pkg::step_type                step,
   output ffe_pkg::phase_type               parse_phase
);

   ffe_pkg::phase_type                 phase_ff, phase_in;
   logic [ffe_pkg::KEY_POS_W-1:0]      key_pos_ff, key_pos_in;
   logic                               key_mis_ff, key_mis_in;
   ffe_pkg::esc_type                   esc_ff, esc_in;
   logic [3:0]                         high_nib_ff, high_nib_in;
   logic [ffe_pkg::VLEN_W-1:0]         count_ff, count_in;

   logic [ffe_pkg::KEY_POS_W-1:0]      klen;
   logic [ffe_pkg::KEY_IDX_W-1:0]      key_idx;
   logic [ffe_pkg::BYTE_W-1:0]         key_char;
   logic [4:0]                         hex;
   logic                               body_end;
   logic                               give_req;
   logic [ffe_pkg::BYTE_W-1:0]         give_val;
   logic                               fin_req;
   ffe_pkg::status_type                fin_st;
   logic                               take_valid;
   ffe_pkg::result_type                take_res;
   logic                               end_valid;
   ffe_pkg::result_type                end_res;

   // Clamp the key length to the key store.
   assign klen = (cfg.key_chars > ffe_pkg::KEY_LEN_W'(ffe_pkg::KEY_MAX_BYTES))
               ? ffe_pkg::KEY_POS_W'(ffe_pkg::KEY_MAX_BYTES)
               : ffe_pkg::KEY_POS_W'(cfg.key_chars);
   assign key_idx  = key_pos_ff[ffe_pkg::KEY_IDX_W-1:0];
   assign key_char = cfg.key_bytes[{key_idx, 3'b000} +: ffe_pkg::BYTE_W];
   assign hex      = ffe_pkg::hex_nibble(body_byte);
   assign body_end = (body_byte == ffe_pkg::CH_NUL) || body_last;

   assign parse_phase = phase_ff;

   always_comb begin
      phase_in    = phase_ff;
      key_pos_in  = key_pos_ff;
      key_mis_in  = key_mis_ff;
      esc_in      = esc_ff;
      high_nib_in = high_nib_ff;
      count_in    = count_ff;
      give_req    = 1'b0;
      give_val    = ffe_pkg::CH_NUL;
      fin_req     = 1'b0;
      fin_st      = ffe_pkg::ST_FOUND;
      take_valid  = 1'b0;
      take_res    = '0;
      end_valid   = 1'b0;
      end_res     = '0;

      if (body_byte != ffe_pkg::CH_NUL) begin
         case (phase_ff)
            ffe_pkg::PH_KEY: begin
               if (body_byte == ffe_pkg::CH_AMP) begin
                  key_pos_in = '0;
                  key_mis_in = 1'b0;
               end else if (body_byte == ffe_pkg::CH_EQ) begin
                  if (!key_mis_ff && key_pos_ff == klen) begin
                     phase_in = ffe_pkg::PH_VALUE;
                     esc_in   = ffe_pkg::ESC_NONE;
                     count_in = '0;
                  end else begin
                     phase_in = ffe_pkg::PH_SKIP;
                  end
               end else if (key_pos_ff < klen && body_byte == key_char) begin
                  key_pos_in = key_pos_ff + 1'b1;
               end else begin
                  key_mis_in = 1'b1;
               end
            end
            ffe_pkg::PH_SKIP: begin
               if (body_byte == ffe_pkg::CH_AMP) begin
                  phase_in   = ffe_pkg::PH_KEY;
                  key_pos_in = '0;
                  key_mis_in = 1'b0;
               end
            end
            ffe_pkg::PH_VALUE: begin
               if (esc_ff == ffe_pkg::ESC_NONE) begin
                  if (body_byte == ffe_pkg::CH_AMP) begin
                     fin_req = 1'b1;
                     fin_st  = ffe_pkg::ST_FOUND;
                  end else if (body_byte == ffe_pkg::CH_PLUS) begin
                     give_req = 1'b1;
                     give_val = ffe_pkg::CH_SPACE;
                  end else if (body_byte == ffe_pkg::CH_PCT) begin
                     esc_in = ffe_pkg::ESC_PCT;
                  end else begin
                     give_req = 1'b1;
                     give_val = body_byte;
                  end
               end else if (body_byte == ffe_pkg::CH_AMP || hex[4]) begin
                  fin_req = 1'b1;
                  fin_st  = ffe_pkg::ST_DECODE_FAIL;
               end else if (esc_ff == ffe_pkg::ESC_PCT) begin
                  high_nib_in = hex[3:0];
                  esc_in      = ffe_pkg::ESC_HIGH;
               end else begin
                  esc_in   = ffe_pkg::ESC_NONE;
                  give_req = 1'b1;
                  give_val = {high_nib_ff, hex[3:0]};
               end
            end
            default: begin
            end
         endcase
      end

      // A decoded zero or a byte past the limit closes the value as a failure.
      if (give_req) begin
         if (give_val == ffe_pkg::CH_NUL || count_ff >= cfg.max_value_len) begin
            fin_req = 1'b1;
            fin_st  = ffe_pkg::ST_DECODE_FAIL;
         end else begin
            count_in            = count_ff + 1'b1;
            take_valid          = 1'b1;
            take_res.value_byte = give_val;
         end
      end

      if (fin_req) begin
         phase_in           = ffe_pkg::PH_DONE;
         esc_in             = ffe_pkg::ESC_NONE;
         take_valid         = 1'b1;
         take_res.is_status = 1'b1;
         take_res.status    = fin_st;
      end

      if (body_end) begin
         if (phase_in != ffe_pkg::PH_DONE) begin
            end_valid         = 1'b1;
            end_res.is_status = 1'b1;
            if (phase_in == ffe_pkg::PH_VALUE) begin
               end_res.status = (esc_in != ffe_pkg::ESC_NONE) ? ffe_pkg::ST_DECODE_FAIL
                                                              : ffe_pkg::ST_FOUND;
            end else begin
               end_res.status = ffe_pkg::ST_NOT_FOUND;
            end
         end
         phase_in    = ffe_pkg::PH_KEY;
         key_pos_in  = '0;
         key_mis_in  = 1'b0;
         esc_in      = ffe_pkg::ESC_NONE;
         high_nib_in = '0;
         count_in    = '0;
      end

      take_res.last_of_run = !end_valid;
      end_res.last_of_run  = 1'b1;

      step.count    = {take_valid & end_valid, take_valid ^ end_valid};
      step.first    = take_valid ? take_res : end_res;
      step.second   = end_res;
      step.body_end = body_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ffe_pkg::PH_KEY;
         key_pos_ff  <= '0;
         key_mis_ff  <= 1'b0;
         esc_ff      <= ffe_pkg::ESC_NONE;
         high_nib_ff <= '0;
         count_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         key_pos_ff  <= key_pos_in;
         key_mis_ff  <= key_mis_in;
         esc_ff      <= esc_in;
         high_nib_ff <= high_nib_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ffe_rsp_queue.sv
// Two-slot result queue: takes up to two results a cycle, gives one while pop_ready is set.
`default_nettype none

module ffe_rsp_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [ffe_pkg::QCNT_W-1:0]   push_count,
   input  wire ffe_pkg::result_type          push_first,
   input  wire ffe_pkg::result_type          push_second,
   input  wire logic                         pop_ready,
   output ffe_pkg::result_type               head,
   output logic                              head_valid,
   output logic [ffe_pkg::QCNT_W-1:0]        free_count
);

   ffe_pkg::result_type            slot0_ff, slot0_in;
   ffe_pkg::result_type            slot1_ff, slot1_in;
   logic [ffe_pkg::QCNT_W-1:0]     fill_ff, fill_in;
   logic [ffe_pkg::QCNT_W-1:0]     fill_after;
   logic                           pop;

   assign head       = slot0_ff;
   assign head_valid = (fill_ff != '0);
   assign pop        = head_valid && pop_ready;
   assign fill_after = fill_ff - ffe_pkg::QCNT_W'(pop);
   assign free_count = ffe_pkg::QCNT_W'(ffe_pkg::QUEUE_DEPTH) - fill_after;

   always_comb begin
      slot0_in = pop ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (push_count != '0) begin
         if (fill_after == '0) begin
            slot0_in = push_first;
         end else begin
            slot1_in = push_first;
         end
      end
      // Two pushes only ever land in an empty queue.
      if (push_count == ffe_pkg::QCNT_W'(ffe_pkg::QUEUE_DEPTH)) begin
         slot1_in = push_second;
      end
      fill_in = fill_after + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire
